// ----- hdl/dlpc_pkg.sv -----
package dlpc_pkg;

  // input item modes
  localparam logic [1:0] MODE_FRAME = 2'd0;
  localparam logic [1:0] MODE_CMD   = 2'd1;
  localparam logic [1:0] MODE_POLL  = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // host commands
  localparam logic [3:0] CMD_NOOP      = 4'd0;
  localparam logic [3:0] CMD_STOP      = 4'd1;
  localparam logic [3:0] CMD_UP        = 4'd2;
  localparam logic [3:0] CMD_DOWN      = 4'd3;
  localparam logic [3:0] CMD_SEEK_UP   = 4'd4;
  localparam logic [3:0] CMD_SEEK_DOWN = 4'd5;
  localparam logic [3:0] CMD_SEL_POS   = 4'd6;
  localparam logic [3:0] CMD_SEL_MOT   = 4'd7;
  localparam logic [3:0] CMD_SAVE_DOWN = 4'd8;
  localparam logic [3:0] CMD_SAVE_UP   = 4'd9;

  // motion codes seen on the bus
  localparam logic [7:0] MOT_STOP = 8'd252;
  localparam logic [7:0] MOT_UP   = 8'd134;
  localparam logic [7:0] MOT_DOWN = 8'd133;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] REG_FRAME_ID  = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_LOWER     = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_UPPER     = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_WINDOW    = 8'd3;

  typedef enum logic [1:0] {
    SEEK_NONE = 2'd0,
    SEEK_UP   = 2'd1,
    SEEK_DOWN = 2'd2
  } seek_t;

  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_POS  = 2'd1,
    SEL_MOT  = 2'd2
  } sel_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  frame_id;
    logic [15:0] frame_position;
    logic [7:0]  frame_motion;
    logic [3:0]  host_command;
  } in_item_t;

  typedef struct packed {
    logic        up_pin;
    logic        down_pin;
    logic        read_valid;
    logic [15:0] read_data;
    logic        save_write;
    logic        save_slot;
    logic [15:0] save_value;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  frame_id_match;
    logic [15:0] lower_limit;
    logic [15:0] upper_limit;
    logic [7:0]  arrive_window;
  } cfg_regs_t;

endpackage

// ----- hdl/dlpc_cfg.sv -----
module dlpc_cfg
  import dlpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [15:0]        cfg_data,
  output cfg_regs_t          regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_ID: regs_nxt.frame_id_match = cfg_data[7:0];
        REG_LOWER:    regs_nxt.lower_limit    = cfg_data;
        REG_UPPER:    regs_nxt.upper_limit    = cfg_data;
        REG_WINDOW:   regs_nxt.arrive_window  = cfg_data[7:0];
        default:      regs_nxt = regs_r; // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.frame_id_match <= 8'd146;
      regs_r.lower_limit    <= 16'd300;
      regs_r.upper_limit    <= 16'd6300;
      regs_r.arrive_window  <= 8'd100;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ----- hdl/dlpc_core.sv -----
module dlpc_core
  import dlpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_en,
  input  in_item_t  item,
  input  cfg_regs_t regs,
  output out_item_t result
);

  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  mot_r, mot_nxt;
  sel_t        sel_r, sel_nxt;
  seek_t       seek_r, seek_nxt;
  logic [15:0] pdown_r, pdown_nxt;
  logic [15:0] pup_r, pup_nxt;
  logic        up_pin_r, up_pin_nxt;
  logic        down_pin_r, down_pin_nxt;

  logic [15:0] dist_down, dist_up, dist_tgt;
  logic        near_down, near_up;
  logic        in_range;
  logic        e_hit, e_clr;

  // distances from the current position to both presets
  assign dist_down = (pos_r >= pdown_r) ? pos_r - pdown_r : pdown_r - pos_r;
  assign dist_up   = (pos_r >= pup_r)   ? pos_r - pup_r   : pup_r - pos_r;
  assign near_down = dist_down <= {8'd0, regs.arrive_window};
  assign near_up   = dist_up   <= {8'd0, regs.arrive_window};
  assign dist_tgt  = (item.host_command == CMD_SEEK_DOWN) ? dist_down : dist_up;
  assign in_range  = (pos_r > regs.lower_limit) && (pos_r < regs.upper_limit);

  // end-limit / arrival check on the given motion and seek
  function automatic logic edge_hit(input logic [7:0] mot, input seek_t seek,
                                    output logic clr);
    logic lo_hit, hi_hit;
    lo_hit = (pos_r <= regs.lower_limit) && (mot == MOT_DOWN);
    hi_hit = (pos_r >= regs.upper_limit) && (mot == MOT_UP);
    clr    = 1'b0;
    if (pos_r == 16'd0)
      return 1'b0;
    if (lo_hit || hi_hit)
      return 1'b1;
    if ((seek == SEEK_DOWN && near_down) || (seek == SEEK_UP && near_up)) begin
      clr = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always_comb begin
    pos_nxt      = pos_r;
    mot_nxt      = mot_r;
    sel_nxt      = sel_r;
    seek_nxt     = seek_r;
    pdown_nxt    = pdown_r;
    pup_nxt      = pup_r;
    up_pin_nxt   = up_pin_r;
    down_pin_nxt = down_pin_r;
    e_hit        = 1'b0;
    e_clr        = 1'b0;
    result       = '0;

    case (item.mode)
      MODE_FRAME: begin
        if (item.frame_id == regs.frame_id_match) begin
          if (item.frame_position != pos_r && item.frame_position != 16'd0)
            pos_nxt = item.frame_position;
          if (item.frame_motion == MOT_STOP || item.frame_motion == MOT_UP ||
              item.frame_motion == MOT_DOWN)
            mot_nxt = item.frame_motion;
        end
      end
      MODE_CMD: begin
        case (item.host_command)
          CMD_SEL_POS: sel_nxt = SEL_POS;
          CMD_SEL_MOT: sel_nxt = SEL_MOT;
          CMD_STOP:    mot_nxt = MOT_STOP;
          CMD_UP:      mot_nxt = MOT_UP;
          CMD_DOWN:    mot_nxt = MOT_DOWN;
          CMD_SAVE_DOWN, CMD_SAVE_UP: begin
            if (in_range) begin
              result.save_write = 1'b1;
              result.save_value = pos_r;
              if (item.host_command == CMD_SAVE_UP) begin
                result.save_slot = 1'b1;
                pup_nxt = pos_r;
              end else begin
                pdown_nxt = pos_r;
              end
            end
          end
          CMD_SEEK_UP, CMD_SEEK_DOWN: begin
            seek_nxt = (item.host_command == CMD_SEEK_DOWN) ? SEEK_DOWN : SEEK_UP;
            if (dist_tgt < {8'd0, regs.arrive_window})
              mot_nxt = MOT_STOP;
            else if (pos_r > ((item.host_command == CMD_SEEK_DOWN) ? pdown_r : pup_r))
              mot_nxt = MOT_DOWN;
            else
              mot_nxt = MOT_UP;
          end
          default: ; // noop and unused codes still drive below
        endcase
        // drive the pins from the updated motion code
        e_hit = edge_hit(mot_nxt, seek_nxt, e_clr);
        if (mot_nxt == MOT_STOP) begin
          up_pin_nxt   = 1'b1;
          down_pin_nxt = 1'b1;
        end else if (mot_nxt == MOT_UP || mot_nxt == MOT_DOWN) begin
          if (e_clr)
            seek_nxt = SEEK_NONE;
          if (!e_hit) begin
            up_pin_nxt   = (mot_nxt != MOT_UP);
            down_pin_nxt = (mot_nxt != MOT_DOWN);
          end
        end
      end
      MODE_POLL: begin
        e_hit = edge_hit(mot_r, seek_r, e_clr);
        if (e_hit) begin
          up_pin_nxt   = 1'b1;
          down_pin_nxt = 1'b1;
          mot_nxt      = MOT_STOP;
        end
        if (e_clr)
          seek_nxt = SEEK_NONE;
      end
      MODE_READ: begin
        if (sel_r == SEL_POS) begin
          result.read_valid = 1'b1;
          result.read_data  = pos_r;
        end else if (sel_r == SEL_MOT) begin
          result.read_valid = 1'b1;
          result.read_data  = {8'd0, mot_r};
        end
      end
      default: ;
    endcase

    result.up_pin   = up_pin_nxt;
    result.down_pin = down_pin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      mot_r      <= '0;
      sel_r      <= SEL_NONE;
      seek_r     <= SEEK_NONE;
      pdown_r    <= '0;
      pup_r      <= '0;
      up_pin_r   <= 1'b1;
      down_pin_r <= 1'b1;
    end else if (item_en) begin
      pos_r      <= pos_nxt;
      mot_r      <= mot_nxt;
      sel_r      <= sel_nxt;
      seek_r     <= seek_nxt;
      pdown_r    <= pdown_nxt;
      pup_r      <= pup_nxt;
      up_pin_r   <= up_pin_nxt;
      down_pin_r <= down_pin_nxt;
    end
  end

endmodule

// ----- hdl/desk_lift_position_controller.sv -----
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_stall   | in_data (in_item_t)
// out_    | output    | out_valid / out_stall | out_data (out_item_t)
// cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle while out_stall is low; each item sees two register stages
// (input register, then result register): an accepted item is held in the input
// register, then moves on into the result register, which drives out_
// the single-pass update in dlpc_core sets the rate: all state for one item is
// computed combinationally between the input register and the result register
// synchronous active-low reset: presets and position zero, pins both high,
// limits and frame id to their defaults
// out_stall holds the result register; the input register keeps accepting
// until it is full, then in_stall rises
module desk_lift_position_controller
  import dlpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [15:0]        cfg_data
);

  // input register
  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_r;

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r;

  cfg_regs_t regs;
  out_item_t result;
  logic      advance;
  logic      in_accept;

  // config registers, to be written only while idle; dlpc_cfg itself does not enforce it
  dlpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // state update and result for the item in the input register
  dlpc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (advance),
    .item    (in_r),
    .regs    (regs),
    .result  (result)
  );

  // item moves on when the result register is empty or being drained
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign in_valid_nxt  = in_accept || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_accept)
      in_r <= in_data;
    if (advance)
      out_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // the drive never pulls both pins low
  a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.up_pin || out_r.down_pin))
    else $error("both drive pins low");

  // one item never both reads and saves
  a_read_save: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.read_valid && out_r.save_write))
    else $error("read and save in one transaction");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && in_valid_r))
    else $error("input stalled without a held result");

  // an advancing item always lands in the result register
  a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed item lost");

endmodule
